/* hw/rtl/bmhq_pkg.sv */
// shared constants and types for the binary max-heap queue
package bmhq_pkg;

  localparam int DEPTH        = 1024;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int ADDR_BITS    = $clog2(DEPTH);
  localparam int CNT_BITS     = $clog2(DEPTH + 1);
  localparam int CHILD_BITS   = ADDR_BITS + 2;
  localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]    payload;
  } entry_t;

  typedef struct packed {
    status_t                    status;
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]    payload;
    logic [CNT_BITS-1:0]        fill;
  } result_t;

endpackage

/* hw/rtl/bmhq_ram.sv */
// heap entry memory, one write port and two registered read ports
module bmhq_ram #(
  parameter int WIDTH = 64,
  parameter int ADDR  = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ADDR-1:0]  waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ADDR-1:0]  raddr_a,
  input  logic [ADDR-1:0]  raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [2**ADDR];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/bmhq_ctrl.sv */
// heap sequencer: hole-based sift up and sift down over the entry memory
module bmhq_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic                                req_kind,
  input  logic signed [bmhq_pkg::KEY_BITS-1:0] req_key,
  input  logic [bmhq_pkg::PAYLOAD_BITS-1:0]   req_payload,
  output logic                                res_valid,
  input  logic                                res_ready,
  output bmhq_pkg::result_t                   res,
  output logic                                mem_we,
  output logic [bmhq_pkg::ADDR_BITS-1:0]      mem_waddr,
  output bmhq_pkg::entry_t                    mem_wdata,
  output logic [bmhq_pkg::ADDR_BITS-1:0]      mem_raddr_a,
  output logic [bmhq_pkg::ADDR_BITS-1:0]      mem_raddr_b,
  input  bmhq_pkg::entry_t                    mem_rdata_a,
  input  bmhq_pkg::entry_t                    mem_rdata_b
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_EX_RD,
    S_EX_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bmhq_pkg::ADDR_BITS-1:0]  pos_r, pos_nxt;
  logic [bmhq_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  bmhq_pkg::entry_t                mov_r, mov_nxt;
  bmhq_pkg::result_t               res_r, res_nxt;

  logic [bmhq_pkg::ADDR_BITS-1:0]  parent;
  logic [bmhq_pkg::CHILD_BITS-1:0] lc, rc, cnt_ext;
  logic                            lc_ok, rc_ok, take_l, take_r;
  logic signed [bmhq_pkg::KEY_BITS-1:0] best_key;
  logic [bmhq_pkg::CNT_BITS-1:0]   cnt_dec;

  assign parent   = (pos_r - bmhq_pkg::ADDR_BITS'(1)) >> 1;
  assign lc       = {1'b0, pos_r, 1'b1};
  assign rc       = lc + bmhq_pkg::CHILD_BITS'(1);
  assign cnt_ext  = bmhq_pkg::CHILD_BITS'(cnt_r);
  assign lc_ok    = lc < cnt_ext;
  assign rc_ok    = rc < cnt_ext;
  assign take_l   = lc_ok && (mem_rdata_a.key > mov_r.key);
  assign best_key = take_l ? mem_rdata_a.key : mov_r.key;
  assign take_r   = rc_ok && (mem_rdata_b.key > best_key);
  assign cnt_dec  = cnt_r - bmhq_pkg::CNT_BITS'(1);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    mov_nxt     = mov_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = mov_r;
    mem_raddr_a = '0;
    mem_raddr_b = '0;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          res_nxt.status  = bmhq_pkg::ST_OK;
          res_nxt.key     = '0;
          res_nxt.payload = '0;
          res_nxt.fill    = cnt_r;
          if (req_kind == bmhq_pkg::OP_INSERT) begin
            if (cnt_r == bmhq_pkg::CNT_BITS'(bmhq_pkg::DEPTH)) begin
              res_nxt.status = bmhq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              mov_nxt.key     = req_key;
              mov_nxt.payload = req_payload;
              pos_nxt         = cnt_r[bmhq_pkg::ADDR_BITS-1:0];
              cnt_nxt         = cnt_r + bmhq_pkg::CNT_BITS'(1);
              state_nxt       = S_UP_RD;
            end
          end else begin
            if (cnt_r == '0) begin
              res_nxt.status = bmhq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_EX_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we       = 1'b1;
          res_nxt.fill = cnt_r;
          state_nxt    = S_DONE;
        end else begin
          mem_raddr_a = parent;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (mov_r.key > mem_rdata_a.key) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          res_nxt.fill = cnt_r;
          state_nxt    = S_DONE;
        end
      end
      S_EX_RD: begin
        mem_raddr_a = '0;
        mem_raddr_b = cnt_dec[bmhq_pkg::ADDR_BITS-1:0];
        state_nxt   = S_EX_CMP;
      end
      S_EX_CMP: begin
        res_nxt.key     = mem_rdata_a.key;
        res_nxt.payload = mem_rdata_a.payload;
        res_nxt.fill    = cnt_dec;
        cnt_nxt         = cnt_dec;
        mov_nxt         = mem_rdata_b;
        pos_nxt         = '0;
        state_nxt       = (cnt_dec == '0) ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        mem_raddr_a = lc[bmhq_pkg::ADDR_BITS-1:0];
        mem_raddr_b = rc[bmhq_pkg::ADDR_BITS-1:0];
        state_nxt   = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (take_r) begin
          mem_wdata = mem_rdata_b;
          pos_nxt   = rc[bmhq_pkg::ADDR_BITS-1:0];
          state_nxt = S_DN_RD;
        end else if (take_l) begin
          mem_wdata = mem_rdata_a;
          pos_nxt   = lc[bmhq_pkg::ADDR_BITS-1:0];
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r <= pos_nxt;
    mov_r <= mov_nxt;
    res_r <= res_nxt;
  end

endmodule

/* hw/rtl/binary_max_heap_queue_unit.sv */
// top level of the binary max-heap priority queue with its result register
// Priority queue of up to DEPTH (1024) entries, each a signed key with a
// payload handle, kept as a binary max-heap in one memory with two registered
// read ports. One operation is in flight at a time. An insert climbs the new
// entry level by level, and an extract descends the moved entry level by
// level. Each level costs one memory read state and one compare-and-write
// state. A result sits in an output register, so the next operation is
// accepted while it waits.
module binary_max_heap_queue_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic signed [bmhq_pkg::KEY_BITS-1:0] in_prio_key,
  input  logic [bmhq_pkg::PAYLOAD_BITS-1:0]    in_payload,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic signed [bmhq_pkg::KEY_BITS-1:0] out_key,
  output logic [bmhq_pkg::PAYLOAD_BITS-1:0]    out_payload,
  output logic [bmhq_pkg::CNT_BITS-1:0]        out_fill_count
);

  logic                           res_valid, res_ready;
  bmhq_pkg::result_t              res;
  logic                           mem_we;
  logic [bmhq_pkg::ADDR_BITS-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  bmhq_pkg::entry_t               mem_wdata, mem_rdata_a, mem_rdata_b;

  logic                           out_valid_r;
  bmhq_pkg::result_t              out_r;

  bmhq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .req_kind    (in_kind),
    .req_key     (in_prio_key),
    .req_payload (in_payload),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

  bmhq_ram #(
    .WIDTH (bmhq_pkg::ENTRY_BITS),
    .ADDR  (bmhq_pkg::ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_key        = out_r.key;
  assign out_payload    = out_r.payload;
  assign out_fill_count = out_r.fill;

endmodule

/* sim/binary_max_heap_queue_checker.sv */
// checker: heap predictor and comparison of result beats for binary_max_heap_queue_unit
module binary_max_heap_queue_checker
  import bmhq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [KEY_BITS-1:0] in_prio_key,
  input  logic [PAYLOAD_BITS-1:0]    in_payload,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 out_status,
  input  logic signed [KEY_BITS-1:0] out_key,
  input  logic [PAYLOAD_BITS-1:0]    out_payload,
  input  logic [CNT_BITS-1:0]        out_fill_count,
  output int                         pending,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KEY_BITS-1:0] slot_key [DEPTH];
  logic [PAYLOAD_BITS-1:0]    slot_pay [DEPTH];
  int                         held;
  int                         fails;
  result_t                    results_due[$];

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (fails < 40) begin
      $display("%0t heap result %s: got %0h, expected %0h", $time, field, got, want);
    end
    fails++;
  endtask

  function automatic void swap_slots(int a, int b);
    logic signed [KEY_BITS-1:0] k;
    logic [PAYLOAD_BITS-1:0]    p;
    k = slot_key[a];
    p = slot_pay[a];
    slot_key[a] = slot_key[b];
    slot_pay[a] = slot_pay[b];
    slot_key[b] = k;
    slot_pay[b] = p;
  endfunction

  function automatic result_t heap_apply(op_t op, logic signed [KEY_BITS-1:0] key,
                                         logic [PAYLOAD_BITS-1:0] pay);
    result_t r;
    int      pos;
    int      up;
    int      best;
    int      lc;
    int      rc;
    r.status  = ST_OK;
    r.key     = '0;
    r.payload = '0;
    if (op == OP_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_key[held] = key;
        slot_pay[held] = pay;
        pos = held;
        held++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(slot_key[pos] > slot_key[up])) break;
          swap_slots(pos, up);
          pos = up;
        end
      end
    end else if (held == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.key     = slot_key[0];
      r.payload = slot_pay[0];
      held--;
      slot_key[0] = slot_key[held];
      slot_pay[0] = slot_pay[held];
      pos = 0;
      while (1) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = lc + 1;
        if (lc < held && slot_key[lc] > slot_key[best]) best = lc;
        if (rc < held && slot_key[rc] > slot_key[best]) best = rc;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
    r.fill = CNT_BITS'(held);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      results_due.delete();
      held  = 0;
      fails = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat", 64'(out_fill_count), '0);
        end else begin
          want = results_due.pop_front();
          if (out_status != want.status) begin
            report_mismatch("status", 64'(out_status), 64'(want.status));
          end
          if (out_key != want.key) begin
            report_mismatch("key", 64'(out_key), 64'(want.key));
          end
          if (out_payload != want.payload) begin
            report_mismatch("payload", 64'(out_payload), 64'(want.payload));
          end
          if (out_fill_count != want.fill) begin
            report_mismatch("fill", 64'(out_fill_count), 64'(want.fill));
          end
        end
      end
      if (in_valid && in_ready) begin
        results_due.push_back(heap_apply(op_t'(in_kind), in_prio_key, in_payload));
      end
    end
    pending    <= results_due.size();
    fail_count <= fails;
  end

endmodule

/* sim/binary_max_heap_queue_unit_test.sv */
// testbench top: stimulus, flow control and verdict for binary_max_heap_queue_unit
module binary_max_heap_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmhq_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_kind = OP_INSERT;
  logic signed [KEY_BITS-1:0] in_prio_key = '0;
  logic [PAYLOAD_BITS-1:0]    in_payload = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [1:0]                 out_status;
  logic signed [KEY_BITS-1:0] out_key;
  logic [PAYLOAD_BITS-1:0]    out_payload;
  logic [CNT_BITS-1:0]        out_fill_count;
  int                         pending;
  int                         fail_count;
  int                         beats_out = 0;
  int                         held_est = 0;
  bit                         quiet_src = 1'b0;

  binary_max_heap_queue_unit uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_prio_key, .in_payload,
    .out_valid, .out_ready, .out_status, .out_key, .out_payload, .out_fill_count
  );

  binary_max_heap_queue_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_prio_key, .in_payload,
    .out_valid, .out_ready, .out_status, .out_key, .out_payload, .out_fill_count,
    .pending, .fail_count
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("binary_max_heap_queue_unit: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) beats_out <= beats_out + 1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom_range(0, 7) - 4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_op(op_t op, logic signed [KEY_BITS-1:0] key,
                         logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    in_valid    <= 1'b1;
    in_kind     <= op;
    in_prio_key <= key;
    in_payload  <= pay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) begin
      if (held_est < DEPTH) held_est++;
    end else if (held_est > 0) begin
      held_est--;
    end
    if ($urandom_range(0, 63) == 0) quiet_src = !quiet_src;
    gap = quiet_src ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : sink
    int  gap;
    bit  quiet_sink;
    bit  pressed;
    quiet_sink = 1'b0;
    pressed    = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressed && beats_out >= 400) begin
        // long hold-off so the block backs up into its input
        pressed = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) quiet_sink = !quiet_sink;
        gap = quiet_sink ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, extreme keys and payloads, ties
    send_op(OP_EXTRACT, 32'sh7fffffff, '1);
    send_op(OP_INSERT, 0, 0);
    send_op(OP_INSERT, 32'sh7fffffff, 32'hffffffff);
    send_op(OP_INSERT, 32'sh80000000, 32'h5a5a5a5a);
    send_op(OP_INSERT, -1, 32'ha5a5a5a5);
    send_op(OP_INSERT, 5, 32'h1);
    send_op(OP_INSERT, 5, 32'h2);
    send_op(OP_INSERT, 5, 32'h3);
    send_op(OP_INSERT, 1, 32'h80000000);
    repeat (9) send_op(OP_EXTRACT, pick_key(), pick_payload());

    repeat (150) send_op(op_t'($urandom_range(0, 99) >= 55), pick_key(), pick_payload());

    // fill to capacity with a few extracts mixed in
    while (held_est < DEPTH) begin
      send_op(op_t'($urandom_range(0, 99) < 5), pick_key(), pick_payload());
    end
    repeat (3) send_op(OP_INSERT, pick_key(), pick_payload());
    repeat (60) send_op(op_t'($urandom_range(0, 1) != 0), pick_key(), pick_payload());

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("binary_max_heap_queue_unit: match");
    end else begin
      $display("binary_max_heap_queue_unit: mismatch");
    end
    $finish;
  end

endmodule
